[src/nhmc_pkg.sv]
// nhmc_pkg: shared types, codes and constants for the network health mode controller
// no dependencies; imported by network_health_mode_controller
`default_nettype none

package nhmc_pkg;

    // counter width and the width used to compare a counter with a 16-bit limit
    localparam int COUNT_WIDTH = 16;
    localparam int LIMIT_WIDTH = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

    // field widths
    localparam int OP_WIDTH    = 2;
    localparam int ALPHA_WIDTH = 16;
    localparam int SCORE_WIDTH = 16;
    localparam int BW_WIDTH    = 32;
    localparam int RATIO_WIDTH = 16;
    localparam int MODE_WIDTH  = 2;

    // configuration port
    localparam int CFG_ADDR_WIDTH = 5;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int CFG_IDX_WIDTH  = 3;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ANOMALY_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RECOVERY_TICKS_NEEDED = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CLEAR_PERIODS_NEEDED  = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LOSS_FRAC             = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RECOVER_RATIO         = 3'd4;

    // register reset values
    localparam logic [15:0] RST_ANOMALY_THRESHOLD     = 16'd32768;
    localparam logic [15:0] RST_RECOVERY_TICKS_NEEDED = 16'd100;
    localparam logic [15:0] RST_CLEAR_PERIODS_NEEDED  = 16'd3;
    localparam logic [15:0] RST_LOSS_FRAC             = 16'd19661;
    localparam logic [15:0] RST_RECOVER_RATIO         = 16'd55706;

    // event kinds
    localparam logic [OP_WIDTH-1:0] OP_ALPHA = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_SCORE = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_BW    = 2'd2;
    localparam logic [OP_WIDTH-1:0] OP_NONE  = 2'd3;

    // mode codes as reported on the result
    localparam logic [MODE_WIDTH-1:0] MODE_CODE_NORMAL   = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_CODE_DEGRADED = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_CODE_ATTACK   = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_CODE_RECOVERY = 2'd3;

    // upper alpha limits per mode, Q1.15
    localparam logic signed [ALPHA_WIDTH-1:0] ALPHA_MAX_NORMAL   = 16'sd32767;
    localparam logic signed [ALPHA_WIDTH-1:0] ALPHA_MAX_DEGRADED = 16'sd9830;
    localparam logic signed [ALPHA_WIDTH-1:0] ALPHA_MAX_RECOVERY = 16'sd16384;

    // one-hot health mode
    typedef enum logic [3:0] {
        MODE_NORMAL   = 4'b0001,
        MODE_DEGRADED = 4'b0010,
        MODE_ATTACK   = 4'b0100,
        MODE_RECOVERY = 4'b1000
    } mode_t;

    // one-hot mode to its reported code
    function automatic logic [MODE_WIDTH-1:0] mode_code(input mode_t m);
        logic [MODE_WIDTH-1:0] c;
        begin
            unique case (m)
                MODE_NORMAL:   c = MODE_CODE_NORMAL;
                MODE_DEGRADED: c = MODE_CODE_DEGRADED;
                MODE_ATTACK:   c = MODE_CODE_ATTACK;
                MODE_RECOVERY: c = MODE_CODE_RECOVERY;
                default:       c = MODE_CODE_NORMAL;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

[src/network_health_mode_controller.sv]
// network_health_mode_controller: four-mode health controller, one event in, one result out
// depends on nhmc_pkg
`default_nettype none

//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_stall  | op, alpha_value, threat_score, bandwidth
//  out     | out_valid / out_stall| mode, clamped_alpha, accept_connection, mode_changed
//  cfg     | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// an event beat lands in an input register, is processed against the mode state and lands
// in the result register. one event per cycle is sustained while the result is not stalled;
// the bandwidth ratio multipliers set the cycle path. reset clears the mode to normal, all
// counters and bandwidth history, and loads the register defaults. a stalled result holds
// the input register, which then stalls input.

module network_health_mode_controller (
    input  wire                                       clk,
    input  wire                                       rst_n,
    // event input
    input  wire                                       in_valid,
    output logic                                      in_stall,
    input  wire  [nhmc_pkg::OP_WIDTH-1:0]             op,
    input  wire  signed [nhmc_pkg::ALPHA_WIDTH-1:0]   alpha_value,
    input  wire  [nhmc_pkg::SCORE_WIDTH-1:0]          threat_score,
    input  wire  [nhmc_pkg::BW_WIDTH-1:0]             bandwidth,
    // result output
    output logic                                      out_valid,
    input  wire                                       out_stall,
    output logic [nhmc_pkg::MODE_WIDTH-1:0]           mode,
    output logic signed [nhmc_pkg::ALPHA_WIDTH-1:0]   clamped_alpha,
    output logic                                      accept_connection,
    output logic                                      mode_changed,
    // configuration
    input  wire                                       psel,
    input  wire                                       penable,
    input  wire                                       pwrite,
    input  wire  [nhmc_pkg::CFG_ADDR_WIDTH-1:0]       paddr,
    input  wire  [nhmc_pkg::CFG_DATA_WIDTH-1:0]       pwdata,
    output logic [nhmc_pkg::CFG_DATA_WIDTH-1:0]       prdata,
    output logic                                      pready
);

    import nhmc_pkg::*;

    // configuration registers
    logic [15:0] anomaly_threshold_reg;
    logic [15:0] recovery_ticks_needed_reg;
    logic [15:0] clear_periods_needed_reg;
    logic [15:0] loss_frac_reg;
    logic [15:0] recover_ratio_reg;

    logic                     cfg_write;
    logic [CFG_IDX_WIDTH-1:0] cfg_idx;

    // input register
    logic                          in_valid_reg;
    logic [OP_WIDTH-1:0]           op_reg;
    logic signed [ALPHA_WIDTH-1:0] alpha_reg;
    logic [SCORE_WIDTH-1:0]        score_reg;
    logic [BW_WIDTH-1:0]           bw_reg;

    // mode state
    mode_t                         mode_reg, mode_next;
    logic signed [ALPHA_WIDTH-1:0] latest_alpha_reg, latest_alpha_next;
    logic [COUNT_WIDTH-1:0]        tick_cnt_reg, tick_cnt_next;
    logic [COUNT_WIDTH-1:0]        clear_cnt_reg, clear_cnt_next;
    logic [BW_WIDTH-1:0]           last_bw_reg, last_bw_next;
    logic [BW_WIDTH-1:0]           pre_drop_bw_reg, pre_drop_bw_next;
    logic                          changed;

    // result register
    logic                          out_valid_reg;
    logic [MODE_WIDTH-1:0]         mode_out_reg;
    logic signed [ALPHA_WIDTH-1:0] alpha_out_reg;
    logic                          accept_out_reg;
    logic                          changed_out_reg;

    logic process;
    logic accept_in;

    // datapath helpers
    logic [COUNT_WIDTH-1:0]              tick_inc;
    logic [COUNT_WIDTH-1:0]              clear_inc;
    logic                                tick_done;
    logic                                clear_done;
    logic                                anomaly;
    logic [RATIO_WIDTH:0]                keep_frac;
    logic [BW_WIDTH+RATIO_WIDTH:0]       drop_lhs;
    logic [BW_WIDTH+RATIO_WIDTH-1:0]     bw_shifted;
    logic [BW_WIDTH+RATIO_WIDTH-1:0]     recover_rhs;
    logic                                drop_hit;
    logic                                recover_hit;
    logic signed [ALPHA_WIDTH-1:0]       alpha_hi;
    logic signed [ALPHA_WIDTH-1:0]       alpha_clamped;

    // configuration write decode
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = paddr[CFG_ADDR_WIDTH-1:2];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            anomaly_threshold_reg     <= RST_ANOMALY_THRESHOLD;
            recovery_ticks_needed_reg <= RST_RECOVERY_TICKS_NEEDED;
            clear_periods_needed_reg  <= RST_CLEAR_PERIODS_NEEDED;
            loss_frac_reg             <= RST_LOSS_FRAC;
            recover_ratio_reg         <= RST_RECOVER_RATIO;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_ANOMALY_THRESHOLD:     anomaly_threshold_reg     <= pwdata[15:0];
                REG_RECOVERY_TICKS_NEEDED: recovery_ticks_needed_reg <= pwdata[15:0];
                REG_CLEAR_PERIODS_NEEDED:  clear_periods_needed_reg  <= pwdata[15:0];
                REG_LOSS_FRAC:             loss_frac_reg             <= pwdata[15:0];
                REG_RECOVER_RATIO:         recover_ratio_reg         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (cfg_idx)
            REG_ANOMALY_THRESHOLD:     prdata = {16'd0, anomaly_threshold_reg};
            REG_RECOVERY_TICKS_NEEDED: prdata = {16'd0, recovery_ticks_needed_reg};
            REG_CLEAR_PERIODS_NEEDED:  prdata = {16'd0, clear_periods_needed_reg};
            REG_LOSS_FRAC:             prdata = {16'd0, loss_frac_reg};
            REG_RECOVER_RATIO:         prdata = {16'd0, recover_ratio_reg};
            default:                   prdata = '0;
        endcase
    end

    // handshake: input register drains into the result register when it is free
    assign process   = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall  = in_valid_reg & ~process;
    assign accept_in = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= accept_in | (in_valid_reg & ~process);
        end
    end

    always_ff @(posedge clk) begin
        if (accept_in) begin
            op_reg    <= op;
            alpha_reg <= alpha_value;
            score_reg <= threat_score;
            bw_reg    <= bandwidth;
        end
    end

    // saturating counters and their limit checks
    assign tick_inc   = (&tick_cnt_reg) ? tick_cnt_reg : tick_cnt_reg + 1'b1;
    assign clear_inc  = (&clear_cnt_reg) ? clear_cnt_reg : clear_cnt_reg + 1'b1;
    assign tick_done  = CMP_WIDTH'(tick_inc) >= CMP_WIDTH'(recovery_ticks_needed_reg);
    assign clear_done = CMP_WIDTH'(clear_inc) >= CMP_WIDTH'(clear_periods_needed_reg);
    assign anomaly    = score_reg > anomaly_threshold_reg;

    // bandwidth ratio tests in Q0.16
    assign keep_frac   = (RATIO_WIDTH+1)'(1 << RATIO_WIDTH) - {1'b0, loss_frac_reg};
    assign drop_lhs    = last_bw_reg * keep_frac;
    assign bw_shifted  = {bw_reg, {RATIO_WIDTH{1'b0}}};
    assign recover_rhs = pre_drop_bw_reg * recover_ratio_reg;
    assign drop_hit    = (last_bw_reg != '0) & (drop_lhs > {1'b0, bw_shifted});
    assign recover_hit = (pre_drop_bw_reg != '0) & (bw_shifted >= recover_rhs);

    // event handling
    always_comb begin
        mode_next         = mode_reg;
        latest_alpha_next = latest_alpha_reg;
        tick_cnt_next     = tick_cnt_reg;
        clear_cnt_next    = clear_cnt_reg;
        last_bw_next      = last_bw_reg;
        pre_drop_bw_next  = pre_drop_bw_reg;
        changed           = 1'b0;
        case (op_reg)
            OP_ALPHA: begin
                latest_alpha_next = alpha_reg;
                if (mode_reg == MODE_RECOVERY) begin
                    tick_cnt_next = tick_inc;
                    if (tick_done) begin
                        mode_next = MODE_NORMAL;
                        changed   = 1'b1;
                    end
                end
            end
            OP_SCORE: begin
                if (anomaly) begin
                    clear_cnt_next = '0;
                    if (mode_reg != MODE_ATTACK) begin
                        mode_next = MODE_ATTACK;
                        changed   = 1'b1;
                    end
                end else if (mode_reg == MODE_ATTACK) begin
                    clear_cnt_next = clear_inc;
                    if (clear_done) begin
                        mode_next      = MODE_RECOVERY;
                        tick_cnt_next  = '0;
                        clear_cnt_next = '0;
                        changed        = 1'b1;
                    end
                end
            end
            OP_BW: begin
                last_bw_next = bw_reg;
                if (mode_reg == MODE_NORMAL) begin
                    if (drop_hit) begin
                        pre_drop_bw_next = last_bw_reg;
                        mode_next        = MODE_DEGRADED;
                        changed          = 1'b1;
                    end
                end else if (mode_reg == MODE_DEGRADED) begin
                    if (recover_hit) begin
                        mode_next = MODE_NORMAL;
                        changed   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // alpha clamp for the mode after the event
    always_comb begin
        unique case (mode_next)
            MODE_NORMAL:   alpha_hi = ALPHA_MAX_NORMAL;
            MODE_DEGRADED: alpha_hi = ALPHA_MAX_DEGRADED;
            MODE_RECOVERY: alpha_hi = ALPHA_MAX_RECOVERY;
            default:       alpha_hi = '0;
        endcase
        if (mode_next == MODE_ATTACK) begin
            alpha_clamped = '0;
        end else if (latest_alpha_next > alpha_hi) begin
            alpha_clamped = alpha_hi;
        end else begin
            alpha_clamped = latest_alpha_next;
        end
    end

    // mode state update
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg         <= MODE_NORMAL;
            latest_alpha_reg <= '0;
            tick_cnt_reg     <= '0;
            clear_cnt_reg    <= '0;
            last_bw_reg      <= '0;
            pre_drop_bw_reg  <= '0;
        end else if (process) begin
            mode_reg         <= mode_next;
            latest_alpha_reg <= latest_alpha_next;
            tick_cnt_reg     <= tick_cnt_next;
            clear_cnt_reg    <= clear_cnt_next;
            last_bw_reg      <= last_bw_next;
            pre_drop_bw_reg  <= pre_drop_bw_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= process | (out_valid_reg & out_stall);
        end
    end

    always_ff @(posedge clk) begin
        if (process) begin
            mode_out_reg    <= mode_code(mode_next);
            alpha_out_reg   <= alpha_clamped;
            accept_out_reg  <= (mode_next != MODE_ATTACK);
            changed_out_reg <= changed;
        end
    end

    // result beat
    assign out_valid         = out_valid_reg;
    assign mode              = mode_out_reg;
    assign clamped_alpha     = alpha_out_reg;
    assign accept_connection = accept_out_reg;
    assign mode_changed      = changed_out_reg;

endmodule

`default_nettype wire

[dv/network_health_mode_controller_tb.sv]
// testbench: self-checking bench for network_health_mode_controller, with directed events,
// register access and biased random traffic checked against an in-bench mode predictor
// depends on nhmc_pkg and network_health_mode_controller
`default_nettype none

module testbench;

    import nhmc_pkg::*;

    // one expected result beat
    typedef struct packed {
        logic [MODE_WIDTH-1:0]  mode;
        logic [ALPHA_WIDTH-1:0] alpha;
        logic                   accept;
        logic                   changed;
    } health_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [OP_WIDTH-1:0]       op = OP_NONE;
    logic [ALPHA_WIDTH-1:0]    alpha_value = '0;
    logic [SCORE_WIDTH-1:0]    threat_score = '0;
    logic [BW_WIDTH-1:0]       bandwidth = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [MODE_WIDTH-1:0]     mode;
    logic [ALPHA_WIDTH-1:0]    clamped_alpha;
    logic                      accept_connection;
    logic                      mode_changed;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
    logic [CFG_DATA_WIDTH-1:0] pwdata = '0;
    logic [CFG_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    // idle rates in percent for the event sender and the result receiver
    int unsigned send_idle_pct = 13;
    int unsigned recv_idle_pct = 46;
    int unsigned error_count = 0;

    health_result_t expected_results[$];

    // predicted controller state and register copy
    logic [MODE_WIDTH-1:0]         health_mode = MODE_CODE_NORMAL;
    logic signed [ALPHA_WIDTH-1:0] held_alpha = '0;
    logic [COUNT_WIDTH-1:0]        recovery_ticks = '0;
    logic [COUNT_WIDTH-1:0]        clear_count = '0;
    logic [BW_WIDTH-1:0]           prev_bw = '0;
    logic [BW_WIDTH-1:0]           pre_drop_bw = '0;
    logic [15:0]                   cfg_threshold = RST_ANOMALY_THRESHOLD;
    logic [15:0]                   cfg_ticks_needed = RST_RECOVERY_TICKS_NEEDED;
    logic [15:0]                   cfg_clear_needed = RST_CLEAR_PERIODS_NEEDED;
    logic [15:0]                   cfg_loss_frac = RST_LOSS_FRAC;
    logic [15:0]                   cfg_recover_ratio = RST_RECOVER_RATIO;

    network_health_mode_controller u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .alpha_value       (alpha_value),
        .threat_score      (threat_score),
        .bandwidth         (bandwidth),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .mode              (mode),
        .clamped_alpha     (clamped_alpha),
        .accept_connection (accept_connection),
        .mode_changed      (mode_changed),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // random receiver stall
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // saturating counter step
    function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
        return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
    endfunction

    // mode transition, clears both counters on the way into recovery
    function automatic logic enter_mode(input logic [MODE_WIDTH-1:0] m);
        if (health_mode == m)
            return 1'b0;
        health_mode = m;
        if (m == MODE_CODE_RECOVERY)
        begin
            recovery_ticks = '0;
            clear_count = '0;
        end
        return 1'b1;
    endfunction

    // applies one event to the predicted state and returns the result beat it yields
    function automatic health_result_t predict_event(input logic [OP_WIDTH-1:0] kind,
                                                     input logic [15:0] a,
                                                     input logic [15:0] s,
                                                     input logic [31:0] b);
        health_result_t r;
        logic changed;
        logic [31:0] prior_bw;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic signed [ALPHA_WIDTH-1:0] ceiling;
        changed = 1'b0;
        case (kind)
            OP_ALPHA:
            begin
                held_alpha = a;
                if (health_mode == MODE_CODE_RECOVERY)
                begin
                    recovery_ticks = count_up(recovery_ticks);
                    if (recovery_ticks >= cfg_ticks_needed)
                        changed = enter_mode(MODE_CODE_NORMAL);
                end
            end
            OP_SCORE:
            begin
                if (s > cfg_threshold)
                begin
                    clear_count = '0;
                    changed = enter_mode(MODE_CODE_ATTACK);
                end
                else if (health_mode == MODE_CODE_ATTACK)
                begin
                    clear_count = count_up(clear_count);
                    if (clear_count >= cfg_clear_needed)
                        changed = enter_mode(MODE_CODE_RECOVERY);
                end
            end
            OP_BW:
            begin
                prior_bw = prev_bw;
                prev_bw = b;
                if (health_mode == MODE_CODE_NORMAL && prior_bw != 0)
                begin
                    // drop: prior * (1 - loss_frac) > new, all in Q0.16
                    lhs = 64'(prior_bw) * (64'd65536 - 64'(cfg_loss_frac));
                    rhs = 64'(b) << 16;
                    if (lhs > rhs)
                    begin
                        pre_drop_bw = prior_bw;
                        changed = enter_mode(MODE_CODE_DEGRADED);
                    end
                end
                else if (health_mode == MODE_CODE_DEGRADED && pre_drop_bw != 0)
                begin
                    lhs = 64'(b) << 16;
                    rhs = 64'(pre_drop_bw) * 64'(cfg_recover_ratio);
                    if (lhs >= rhs)
                        changed = enter_mode(MODE_CODE_NORMAL);
                end
            end
            default:
            begin
            end
        endcase
        case (health_mode)
            MODE_CODE_NORMAL:   ceiling = ALPHA_MAX_NORMAL;
            MODE_CODE_DEGRADED: ceiling = ALPHA_MAX_DEGRADED;
            default:            ceiling = ALPHA_MAX_RECOVERY;
        endcase
        r.mode = health_mode;
        if (health_mode == MODE_CODE_ATTACK)
            r.alpha = '0;
        else
            r.alpha = (held_alpha > ceiling) ? ceiling : held_alpha;
        r.accept = (health_mode != MODE_CODE_ATTACK);
        r.changed = changed;
        return r;
    endfunction

    // level scaled by a Q16.16 factor, saturated to 32 bits
    function automatic logic [31:0] scale_bw(input logic [31:0] level, input int unsigned frac);
        logic [63:0] w;
        w = (64'(level) * 64'(frac)) >> 16;
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    // send one event beat, with random idle cycles ahead of it
    task automatic send_event(input logic [OP_WIDTH-1:0] kind, input logic [15:0] a,
                              input logic [15:0] s, input logic [31:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        alpha_value <= a;
        threat_score <= s;
        bandwidth <= b;
        do
            @(negedge clk);
        while (in_stall !== 1'b0);
        @(posedge clk);
        expected_results.push_back(predict_event(kind, a, s, b));
    endtask

    // drain all outstanding results before touching registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write: setup cycle then access cycle
    task automatic write_register(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_WIDTH'(idx) << 2;
        pwdata <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (pready !== 1'b1);
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ANOMALY_THRESHOLD:     cfg_threshold = value;
            REG_RECOVERY_TICKS_NEEDED: cfg_ticks_needed = value;
            REG_CLEAR_PERIODS_NEEDED:  cfg_clear_needed = value;
            REG_LOSS_FRAC:             cfg_loss_frac = value;
            REG_RECOVER_RATIO:         cfg_recover_ratio = value;
            default:
            begin
            end
        endcase
    endtask

    // register read and compare
    task automatic check_register(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [15:0] value);
        logic [CFG_DATA_WIDTH-1:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= CFG_ADDR_WIDTH'(idx) << 2;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (pready !== 1'b1);
        readback = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (readback !== {16'h0000, value})
        begin
            error_count++;
            $error("prdata mismatch at register %0d: expected %0d, got %0d", idx, value, readback);
        end
    endtask

    // reset values, extremes and restore of every register
    task automatic test_register_access();
        check_register(REG_ANOMALY_THRESHOLD, RST_ANOMALY_THRESHOLD);
        check_register(REG_RECOVERY_TICKS_NEEDED, RST_RECOVERY_TICKS_NEEDED);
        check_register(REG_CLEAR_PERIODS_NEEDED, RST_CLEAR_PERIODS_NEEDED);
        check_register(REG_LOSS_FRAC, RST_LOSS_FRAC);
        check_register(REG_RECOVER_RATIO, RST_RECOVER_RATIO);
        for (int i = REG_ANOMALY_THRESHOLD; i <= REG_RECOVER_RATIO; i++)
        begin
            write_register(CFG_IDX_WIDTH'(i), 16'hFFFF);
            check_register(CFG_IDX_WIDTH'(i), 16'hFFFF);
            write_register(CFG_IDX_WIDTH'(i), 16'h0000);
            check_register(CFG_IDX_WIDTH'(i), 16'h0000);
        end
        write_register(REG_ANOMALY_THRESHOLD, RST_ANOMALY_THRESHOLD);
        write_register(REG_RECOVERY_TICKS_NEEDED, RST_RECOVERY_TICKS_NEEDED);
        write_register(REG_CLEAR_PERIODS_NEEDED, RST_CLEAR_PERIODS_NEEDED);
        write_register(REG_LOSS_FRAC, RST_LOSS_FRAC);
        write_register(REG_RECOVER_RATIO, RST_RECOVER_RATIO);
    endtask

    // walk through every mode with default registers
    task automatic test_directed_events();
        // empty event reports state only
        send_event(OP_NONE, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF);
        // alpha extremes in normal mode
        send_event(OP_ALPHA, 16'h7FFF, 16'h0000, 32'h0);
        send_event(OP_ALPHA, 16'h8000, 16'h0000, 32'h0);
        // no previous bandwidth, so neither beat can count as a drop
        send_event(OP_BW, 16'h0000, 16'h0000, 32'h0);
        send_event(OP_BW, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        // full drop enters degraded
        send_event(OP_BW, 16'h0000, 16'h0000, 32'h0);
        send_event(OP_ALPHA, 16'h7FFF, 16'h0000, 32'h0);
        send_event(OP_BW, 16'h0000, 16'h0000, 32'h0);
        send_event(OP_BW, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        // score equal to threshold is clear, above it is an anomaly
        send_event(OP_SCORE, 16'h0000, 16'h8000, 32'h0);
        send_event(OP_SCORE, 16'h0000, 16'hFFFF, 32'h0);
        send_event(OP_SCORE, 16'h0000, 16'h0000, 32'h0);
        // anomaly under attack restarts the clear count
        send_event(OP_SCORE, 16'h0000, 16'h8001, 32'h0);
        // bandwidth history still tracked under attack
        send_event(OP_BW, 16'h0000, 16'h0000, 32'd12345);
        send_event(OP_SCORE, 16'h0000, 16'h8000, 32'h0);
        send_event(OP_SCORE, 16'h0000, 16'h0000, 32'h0);
        send_event(OP_SCORE, 16'h0000, 16'd100, 32'h0);
        // recovery clamps at one half
        send_event(OP_ALPHA, 16'd16385, 16'h0000, 32'h0);
        send_event(OP_ALPHA, 16'hFFFF, 16'h0000, 32'h0);
        send_event(OP_SCORE, 16'h0000, 16'hFFFF, 32'h0);
    endtask

    // zero needed counts are met by the first qualifying event
    task automatic test_zero_counts();
        wait_idle();
        write_register(REG_ANOMALY_THRESHOLD, 16'h0000);
        write_register(REG_CLEAR_PERIODS_NEEDED, 16'h0000);
        write_register(REG_RECOVERY_TICKS_NEEDED, 16'h0000);
        send_event(OP_SCORE, 16'h0000, 16'h0000, 32'h0);
        send_event(OP_ALPHA, 16'd5, 16'h0000, 32'h0);
        send_event(OP_SCORE, 16'h0000, 16'h0001, 32'h0);
    endtask

    // random events steered by the predicted mode so every transition keeps recurring
    task automatic test_random_traffic(input int unsigned items, input int unsigned send_pct,
                                       input int unsigned recv_pct, input logic [15:0] thr,
                                       input logic [15:0] ticks, input logic [15:0] clears,
                                       input logic [15:0] drop, input logic [15:0] recover);
        int unsigned sent;
        int unsigned roll;
        int unsigned w_alpha;
        int unsigned w_score;
        logic [OP_WIDTH-1:0] kind;
        logic [15:0] a;
        logic [15:0] s;
        logic [31:0] b;
        wait_idle();
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        write_register(REG_ANOMALY_THRESHOLD, thr);
        write_register(REG_RECOVERY_TICKS_NEEDED, ticks);
        write_register(REG_CLEAR_PERIODS_NEEDED, clears);
        write_register(REG_LOSS_FRAC, drop);
        write_register(REG_RECOVER_RATIO, recover);
        sent = 0;
        while (sent < items)
        begin
            // event kind weighted by mode
            case (health_mode)
                MODE_CODE_ATTACK:   begin w_alpha = 20; w_score = 65; end
                MODE_CODE_RECOVERY: begin w_alpha = 60; w_score = 15; end
                MODE_CODE_DEGRADED: begin w_alpha = 25; w_score = 20; end
                default:            begin w_alpha = 30; w_score = 25; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 5)
                kind = OP_NONE;
            else if (roll < 5 + w_alpha)
                kind = OP_ALPHA;
            else if (roll < 5 + w_alpha + w_score)
                kind = OP_SCORE;
            else
                kind = OP_BW;
            a = 16'($urandom);
            s = 16'($urandom);
            b = $urandom;
            // alpha: extremes and values around the clamp limits
            roll = $urandom_range(0, 99);
            if (roll < 10)
                a = roll[0] ? 16'h7FFF : 16'h8000;
            else if (roll < 25)
                a = 16'(ALPHA_MAX_DEGRADED + $urandom_range(0, 2) - 1);
            else if (roll < 40)
                a = 16'(ALPHA_MAX_RECOVERY + $urandom_range(0, 2) - 1);
            // score: anomalies rarer under attack so that attack can be left
            roll = $urandom_range(0, 99);
            if (roll < ((health_mode == MODE_CODE_ATTACK) ? 12 : 35))
            begin
                if (cfg_threshold != 16'hFFFF)
                    s = 16'($urandom_range(32'(cfg_threshold) + 1, 32'hFFFF));
            end
            else if (roll < 90)
                s = 16'($urandom_range(0, 32'(cfg_threshold)));
            // bandwidth: near the drop and recovery thresholds, with some raw values
            roll = $urandom_range(0, 99);
            if (roll < 4)
                b = '0;
            else if (roll < 8)
                b = '1;
            else if (roll < 18)
                b = b;
            else if (health_mode == MODE_CODE_DEGRADED)
                b = scale_bw(pre_drop_bw, $urandom_range(40000, 80000));
            else if (roll < 26)
                b = scale_bw(prev_bw, $urandom_range(0, 3));
            else if (prev_bw != 0)
                b = scale_bw(prev_bw, $urandom_range(30000, 75000));
            send_event(kind, a, s, b);
            if (kind != OP_NONE)
                sent++;
        end
    endtask

    // result checker: a beat is taken at the next rising edge when valid and not stalled
    always @(negedge clk)
    begin
        health_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $error("result beat with no expected result pending");
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (mode !== want.mode)
                begin
                    error_count++;
                    $error("mode mismatch: expected %0d, got %0d", want.mode, mode);
                end
                if (clamped_alpha !== want.alpha)
                begin
                    error_count++;
                    $error("clamped_alpha mismatch: expected %0d, got %0d",
                           $signed(want.alpha), $signed(clamped_alpha));
                end
                if (accept_connection !== want.accept)
                begin
                    error_count++;
                    $error("accept_connection mismatch: expected %0d, got %0d",
                           want.accept, accept_connection);
                end
                if (mode_changed !== want.changed)
                begin
                    error_count++;
                    $error("mode_changed mismatch: expected %0d, got %0d",
                           want.changed, mode_changed);
                end
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_events();
        test_zero_counts();
        test_random_traffic(700, 13, 46, 16'($urandom_range(16384, 49152)), 16'd8, 16'd2,
                            RST_LOSS_FRAC, RST_RECOVER_RATIO);
        test_random_traffic(600, 46, 13, 16'h0000, 16'd1, 16'd1, 16'h0000, 16'h0000);
        test_random_traffic(200, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_random_traffic(500, 0, 0, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(1, 12)), 16'($urandom_range(0, 5)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
src/nhmc_pkg.sv
src/network_health_mode_controller.sv
dv/network_health_mode_controller_tb.sv
